// ----- src/i2cms_pkg.sv -----
package i2cms_pkg;

	localparam int unsigned CFG_W = 16;
	localparam int unsigned CFG_ADDR_W = 1;

	localparam logic [CFG_ADDR_W-1:0] REG_ACK_POLL_LIMIT   = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_PHASE_HOLD_TICKS = 1'b1;

	localparam logic [CFG_W-1:0] ACK_POLL_LIMIT_RST   = 16'd250;
	localparam logic [CFG_W-1:0] PHASE_HOLD_TICKS_RST = 16'd1;
	localparam logic [CFG_W-1:0] POLL_MAX             = 16'hFFFF;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [2:0] {
		ACT_NONE     = 3'd0,
		ACT_BEGIN_WR = 3'd1,
		ACT_BEGIN_RD = 3'd2,
		ACT_WR_BYTE  = 3'd3,
		ACT_RD_BYTE  = 3'd4,
		ACT_STOP     = 3'd5
	} action_t;

	typedef enum logic [4:0] {
		PH_IDLE_HI       = 5'd0,
		PH_START_SCL_HI  = 5'd1,
		PH_START_SDA_LO  = 5'd2,
		PH_BIT_SCL_LO    = 5'd3,
		PH_BIT_SDA       = 5'd4,
		PH_BIT_SCL_HI    = 5'd5,
		PH_ACK_SCL_LO    = 5'd6,
		PH_ACK_RELEASE   = 5'd7,
		PH_ACK_SCL_HI    = 5'd8,
		PH_ACK_POLL      = 5'd9,
		PH_RD_RELEASE    = 5'd10,
		PH_RD_SCL_LO     = 5'd11,
		PH_RD_SCL_HI     = 5'd12,
		PH_RD_SAMPLE     = 5'd13,
		PH_MACK_SCL_LO   = 5'd14,
		PH_MACK_SDA      = 5'd15,
		PH_MACK_SCL_HI   = 5'd16,
		PH_MACK_SCL_DONE = 5'd17,
		PH_STOP_SCL_LO   = 5'd18,
		PH_STOP_SDA_LO   = 5'd19,
		PH_STOP_SCL_HI   = 5'd20,
		PH_STOP_SDA_HI   = 5'd21,
		PH_FINISH        = 5'd22
	} phase_t;

	typedef struct packed {
		action_t     cmd;
		phase_t      phase;
		logic [3:0]  bit_index;
		logic [7:0]  shift;
		logic [7:0]  remaining;
		logic [15:0] poll;
		logic [15:0] hold;
		logic        scl;
		logic        sda;
		logic        sda_drive;
		logic        ack;
		logic [7:0]  read_data;
	} state_t;

	localparam state_t STATE_RST = '{
		cmd:       ACT_NONE,
		phase:     PH_IDLE_HI,
		bit_index: 4'd0,
		shift:     8'd0,
		remaining: 8'd0,
		poll:      16'd0,
		hold:      16'd0,
		scl:       1'b1,
		sda:       1'b1,
		sda_drive: 1'b1,
		ack:       1'b0,
		read_data: 8'd0
	};

	typedef struct packed {
		logic [2:0] action;
		logic [6:0] target_address;
		logic [7:0] write_data;
		logic [7:0] read_length;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic [7:0] bytes_left;
		logic [7:0] read_byte;
		logic       ack_received;
		logic       done_res;
		logic       busy_res;
		logic       sda_drive;
		logic       sda_level;
		logic       scl_level;
	} result_t;

endpackage

// ----- src/i2c_master_bit_sequencer.sv -----
// I2C master bit sequencer. Each input item is one bus tick carrying a command in tuser
// and the address, write byte, read length and sampled SDA in tdata; each item gives
// exactly one result item with the SCL, SDA and SDA-enable levels after that tick and
// the status. One item is taken every clock while no result waits on a stalled output;
// the item is captured in the input register when accepted and the phase logic then
// loads the result register, which presents the result. Items stall only while the
// input register is full and a finished result waits on the output. Commands are taken
// only when the sequencer is idle and are otherwise ignored; each pin phase is held for
// phase_hold_ticks ticks, ACK polling runs one sample per tick until its poll count
// passes ack_poll_limit. Configuration may be written only while no command is running.
module i2c_master_bit_sequencer import i2cms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// action
	input  logic [2:0]            s_axis_tuser,
	// target_address, write_data, read_length, sda_in
	input  logic [23:0]           s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// scl_level, sda_level, sda_drive, busy_res, done_res, ack_received,
	// read_byte, bytes_left, zero pad
	output logic [23:0]           m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]      cfg_data
);

	logic [CFG_W-1:0] ack_poll_limit_q;
	logic [CFG_W-1:0] phase_hold_ticks_q;
	item_t            item_s1;
	logic             valid_s1;
	state_t           state_q;
	state_t           state_next;
	result_t          res;
	result_t          res_q;
	logic             res_valid_q;
	logic             accept;
	logic             advance;

	assign advance       = valid_s1 && (!res_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_poll_limit_q   <= ACK_POLL_LIMIT_RST;
			phase_hold_ticks_q <= PHASE_HOLD_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ACK_POLL_LIMIT:   ack_poll_limit_q <= cfg_data;
				REG_PHASE_HOLD_TICKS: phase_hold_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.action         <= s_axis_tuser;
			item_s1.target_address <= s_axis_tdata[6:0];
			item_s1.write_data     <= s_axis_tdata[14:7];
			item_s1.read_length    <= s_axis_tdata[22:15];
			item_s1.sda_in         <= s_axis_tdata[23];
		end
	end

	i2cms_step u_step (
		.st               (state_q),
		.item             (item_s1),
		.ack_poll_limit   (ack_poll_limit_q),
		.phase_hold_ticks (phase_hold_ticks_q),
		.st_next          (state_next),
		.res              (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RST;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_next;
			res_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = {2'b00, res_q.bytes_left, res_q.read_byte, res_q.ack_received,
		res_q.done_res, res_q.busy_res, res_q.sda_drive, res_q.sda_level, res_q.scl_level};

endmodule

// ----- src/i2cms_step.sv -----
module i2cms_step import i2cms_pkg::*; (
	input  state_t      st,
	input  item_t       item,
	input  logic [15:0] ack_poll_limit,
	input  logic [15:0] phase_hold_ticks,
	output state_t      st_next,
	output result_t     res
);

	state_t      n;
	logic        run;
	logic        done;
	logic        finished;
	logic        hold_en;
	phase_t      nxt;
	logic [15:0] hold_load;
	logic [3:0]  bi;
	logic [7:0]  sh;

	// a hold of zero behaves as one
	assign hold_load = (phase_hold_ticks == 16'd0) ? 16'd0 : phase_hold_ticks - 16'd1;

	always_comb begin
		n        = st;
		run      = 1'b0;
		done     = 1'b0;
		finished = 1'b0;
		hold_en  = 1'b1;
		nxt      = PH_IDLE_HI;
		bi       = 4'd0;
		sh       = 8'd0;

		if (st.cmd == ACT_NONE) begin
			if (item.action >= ACT_BEGIN_WR && item.action <= ACT_STOP) begin
				n.bit_index = 4'd0;
				n.poll      = 16'd0;
				n.hold      = 16'd0;
				run         = 1'b1;
				n.cmd       = action_t'(item.action);
				case (action_t'(item.action))
					ACT_BEGIN_WR, ACT_BEGIN_RD: begin
						n.shift = {item.target_address, item.action == ACT_BEGIN_RD};
						if (item.action == ACT_BEGIN_RD)
							n.remaining = item.read_length;
						n.phase = PH_IDLE_HI;
					end
					ACT_WR_BYTE: begin
						n.shift = item.write_data;
						n.phase = PH_BIT_SCL_LO;
					end
					ACT_RD_BYTE: begin
						// nothing left to read: complete at once, pins untouched
						if (st.remaining == 8'd0) begin
							n.read_data = 8'd0;
							n.cmd       = ACT_NONE;
							done        = 1'b1;
							run         = 1'b0;
						end else begin
							n.phase = PH_RD_RELEASE;
						end
					end
					default: n.phase = PH_STOP_SCL_LO;
				endcase
			end
		end else if (st.hold != 16'd0) begin
			n.hold = st.hold - 16'd1;
		end else begin
			run = 1'b1;
		end

		if (run) begin
			nxt = phase_t'(n.phase + 5'd1);
			case (n.phase)
				PH_IDLE_HI: begin
					n.sda = 1'b1;
					n.sda_drive = 1'b1;
				end
				PH_START_SCL_HI: n.scl = 1'b1;
				PH_START_SDA_LO: begin
					n.sda = 1'b0;
					n.sda_drive = 1'b1;
				end
				PH_BIT_SCL_LO: n.scl = 1'b0;
				PH_BIT_SDA: begin
					n.sda = n.shift[7];
					n.sda_drive = 1'b1;
					n.shift = {n.shift[6:0], 1'b0};
				end
				PH_BIT_SCL_HI: begin
					n.scl = 1'b1;
					bi = n.bit_index + 4'd1;
					n.bit_index = bi;
					nxt = (bi < BITS_PER_BYTE) ? PH_BIT_SCL_LO : PH_ACK_SCL_LO;
				end
				PH_ACK_SCL_LO: n.scl = 1'b0;
				PH_ACK_RELEASE: n.sda_drive = 1'b0;
				PH_ACK_SCL_HI: begin
					n.scl = 1'b1;
					n.poll = 16'd0;
				end
				PH_ACK_POLL: begin
					// sampled every tick, no hold
					hold_en = 1'b0;
					if (item.sda_in == 1'b0) begin
						n.ack = 1'b1;
						nxt = PH_FINISH;
					end else if (n.poll > ack_poll_limit) begin
						n.ack = 1'b0;
						nxt = PH_FINISH;
					end else begin
						if (n.poll != POLL_MAX)
							n.poll = n.poll + 16'd1;
						nxt = PH_ACK_POLL;
					end
				end
				PH_RD_RELEASE: begin
					n.sda_drive = 1'b0;
					n.bit_index = 4'd0;
					n.shift = 8'd0;
				end
				PH_RD_SCL_LO: n.scl = 1'b0;
				PH_RD_SCL_HI: n.scl = 1'b1;
				PH_RD_SAMPLE: begin
					sh = {n.shift[6:0], item.sda_in};
					n.shift = sh;
					bi = n.bit_index + 4'd1;
					n.bit_index = bi;
					if (bi < BITS_PER_BYTE) begin
						nxt = PH_RD_SCL_LO;
					end else begin
						n.read_data = sh;
						n.remaining = n.remaining - 8'd1;
					end
				end
				PH_MACK_SCL_LO: n.scl = 1'b0;
				PH_MACK_SDA: begin
					// ack while bytes remain, nak on the last one
					n.sda = (n.remaining == 8'd0);
					n.sda_drive = 1'b1;
				end
				PH_MACK_SCL_HI: n.scl = 1'b1;
				PH_MACK_SCL_DONE: begin
					n.scl = 1'b0;
					nxt = (n.remaining != 8'd0) ? PH_FINISH : PH_STOP_SCL_LO;
				end
				PH_STOP_SCL_LO: n.scl = 1'b0;
				PH_STOP_SDA_LO: begin
					n.sda = 1'b0;
					n.sda_drive = 1'b1;
				end
				PH_STOP_SCL_HI: n.scl = 1'b1;
				PH_STOP_SDA_HI: begin
					n.sda = 1'b1;
					n.sda_drive = 1'b1;
					nxt = PH_FINISH;
				end
				default: begin
					n.cmd = ACT_NONE;
					n.phase = PH_IDLE_HI;
					n.hold = 16'd0;
					done = 1'b1;
					finished = 1'b1;
				end
			endcase
			if (!finished) begin
				n.phase = nxt;
				n.hold = hold_en ? hold_load : 16'd0;
			end
		end
	end

	assign st_next = n;

	always_comb begin
		res.scl_level    = n.scl;
		res.sda_level    = n.sda_drive ? n.sda : 1'b1;
		res.sda_drive    = n.sda_drive;
		res.busy_res     = (n.cmd != ACT_NONE);
		res.done_res     = done;
		res.ack_received = n.ack;
		res.read_byte    = n.read_data;
		res.bytes_left   = n.remaining;
	end

endmodule

// ----- src/i2cms_checker.sv -----
module i2cms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// input side only stalls behind a waiting result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

	// a completing tick leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[3])
		else $error("done reported while still busy");

	// released sda reads high
	a_sda_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[1])
		else $error("sda level low while released");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
